// ----- rtl/core/bbspi_pkg.sv -----
// Shared types and constants for the bit-banged SPI master/slave engine.
`timescale 1ns / 1ps

package bbspi_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned POS_W     = 3;
  localparam int unsigned S_TDATA_W = 16;
  localparam int unsigned M_TDATA_W = 16;

  // tuser code of an input item
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_PUT  = 1'b1;

  // first and last bit position of a byte
  localparam logic [POS_W-1:0] POS_BIT0 = 3'd0;
  localparam logic [POS_W-1:0] POS_LAST = 3'd7;

  typedef enum logic [1:0] {
    CMD_PUT,
    CMD_MTICK,
    CMD_STICK
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e             op;
    logic [BYTE_W-1:0]   data;
    logic                en;
    logic                miso;
    logic                mosi;
    logic                sclk;
    logic                sync;
  } cmd_t;

  typedef struct packed {
    logic                dropped;
    logic [BYTE_W-1:0]   rx_byte;
    logic                rx_valid;
    logic                miso;
    logic                sync;
    logic                mosi;
    logic                sclk;
  } rsp_t;

endpackage

// ----- rtl/core/bbspi_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bbspi_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/bbspi_front.sv -----
// Front end: role register, input item decode and classification.
`timescale 1ns / 1ps

module bbspi_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic                             cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [bbspi_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  input  logic                             s_axis_tuser,
  output logic                             push_valid_o,
  input  logic                             push_ready_i,
  output bbspi_pkg::cmd_t                  cmd_o
);

  import bbspi_pkg::*;

  logic is_master_q;
  logic is_master_d;

  always_comb begin
    is_master_d = is_master_q;
    if (cfg_we_i) begin
      is_master_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_master_q <= 1'b0;
    end else begin
      is_master_q <= is_master_d;
    end
  end

  // tdata: put_byte[7:0], enable[8], miso[9], mosi[10], clk[11], sync[12]
  always_comb begin
    cmd_o.data = s_axis_tdata[7:0];
    cmd_o.en   = s_axis_tdata[8];
    cmd_o.miso = s_axis_tdata[9];
    cmd_o.mosi = s_axis_tdata[10];
    cmd_o.sclk = s_axis_tdata[11];
    cmd_o.sync = s_axis_tdata[12];
    if (s_axis_tuser == KIND_PUT) begin
      cmd_o.op = CMD_PUT;
    end else if (is_master_q) begin
      cmd_o.op = CMD_MTICK;
    end else begin
      cmd_o.op = CMD_STICK;
    end
  end

  assign push_valid_o  = s_axis_tvalid;
  assign s_axis_tready = push_ready_i;

endmodule

// ----- rtl/core/bbspi_cmdq.sv -----
// Two-entry command queue between front end and engine.
`timescale 1ns / 1ps

module bbspi_cmdq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  bbspi_pkg::cmd_t push_cmd_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output bbspi_pkg::cmd_t pop_cmd_o
);

  import bbspi_pkg::*;

  localparam logic [1:0] CNT_FULL = 2'd2;

  cmd_t       slot_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign push_ready_o = (cnt_q != CNT_FULL);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_cmd_o    = slot_q[rd_q];

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_cmd_i;
    end
  end

endmodule

// ----- rtl/core/bbspi_engine.sv -----
// Back end: transmit FIFO, shift logic for both roles and result register.
`timescale 1ns / 1ps

module bbspi_engine #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  input  bbspi_pkg::cmd_t cmd_i,
  output logic            rsp_valid_o,
  input  logic            rsp_ready_i,
  output bbspi_pkg::rsp_t rsp_o
);

  import bbspi_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + AW'(1);
  endfunction

  // FIFO bookkeeping; head byte and the one behind it live in flops
  logic [CW-1:0]     count_q, count_d;
  logic [AW-1:0]     head_q, head_d;
  logic [AW-1:0]     tail_q, tail_d;
  logic [BYTE_W-1:0] head_byte_q, head_byte_d;
  logic [BYTE_W-1:0] next_byte_q, next_byte_d;
  logic              nb_ok_q, nb_ok_d;
  logic              rf1_q, rf1_d;
  logic              rf2_q, rf2_d;

  // shift state
  logic [POS_W-1:0]  tx_pos_q, tx_pos_d;
  logic [POS_W-1:0]  rx_pos_q, rx_pos_d;
  logic [BYTE_W-1:0] rx_shift_q, rx_shift_d;
  logic              phase_q, phase_d;
  logic              armed_q, armed_d;
  logic              pin_clk_q, pin_clk_d;
  logic              pin_mosi_q, pin_mosi_d;
  logic              pin_sync_q, pin_sync_d;
  logic              pin_miso_q, pin_miso_d;

  logic              out_valid_q, out_valid_d;
  rsp_t              out_q, out_d;

  logic              fire;
  logic              pop;
  logic              do_take;
  logic              take_lvl;
  logic              we;
  logic [BYTE_W-1:0] hb;
  logic [BYTE_W-1:0] rx_next;
  logic [POS_W-1:0]  tx_pos_inc;
  logic [BYTE_W-1:0] ram_rdata;
  rsp_t              rsp;

  assign cmd_ready_o = !out_valid_q || rsp_ready_i;
  assign fire        = cmd_valid_i && cmd_ready_o;
  assign hb          = (count_q != '0) ? head_byte_q : '0;
  assign tx_pos_inc  = tx_pos_q + POS_W'(1);

  // Backing store; read port always looks one past the head so the
  // entry behind the new head is refilled after a pop, via rf1/rf2 and the registered read.
  bbspi_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_txq_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (tail_q),
    .wdata_i (cmd_i.data),
    .raddr_i (ptr_inc(head_q)),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    count_d     = count_q;
    head_d      = head_q;
    tail_d      = tail_q;
    head_byte_d = head_byte_q;
    next_byte_d = next_byte_q;
    nb_ok_d     = nb_ok_q;
    rf1_d       = 1'b0;
    rf2_d       = rf1_q;
    tx_pos_d    = tx_pos_q;
    rx_pos_d    = rx_pos_q;
    rx_shift_d  = rx_shift_q;
    phase_d     = phase_q;
    armed_d     = armed_q;
    pin_clk_d   = pin_clk_q;
    pin_mosi_d  = pin_mosi_q;
    pin_sync_d  = pin_sync_q;
    pin_miso_d  = pin_miso_q;
    pop         = 1'b0;
    do_take     = 1'b0;
    take_lvl    = 1'b0;
    we          = 1'b0;
    rx_next     = rx_shift_q;
    rsp         = '0;

    // refill of the second entry; pops are at least eight items apart
    if (rf2_q && !nb_ok_q && (count_q > CNT_ONE)) begin
      next_byte_d = ram_rdata;
      nb_ok_d     = 1'b1;
    end

    if (fire) begin
      case (cmd_i.op)
        CMD_PUT: begin
          if (count_q == CNT_FULL) begin
            rsp.dropped = 1'b1;
          end else begin
            we      = 1'b1;
            tail_d  = ptr_inc(tail_q);
            count_d = count_q + CW'(1);
            if (count_q == '0) begin
              head_byte_d = cmd_i.data;
            end
            if (count_q == CNT_ONE) begin
              next_byte_d = cmd_i.data;
              nb_ok_d     = 1'b1;
            end
          end
        end
        CMD_MTICK: begin
          if (!cmd_i.en) begin
            pin_clk_d = 1'b0;
            phase_d   = 1'b0;
          end else begin
            phase_d   = ~phase_q;
            pin_clk_d = ~pin_clk_q;
            if (phase_q) begin
              // falling edge: sample
              do_take  = 1'b1;
              take_lvl = cmd_i.miso;
            end else begin
              // rising edge: drive
              pin_sync_d = (tx_pos_q == POS_BIT0);
              pin_mosi_d = hb[tx_pos_q];
              tx_pos_d   = tx_pos_inc;
              pop        = (tx_pos_q == POS_LAST);
            end
          end
        end
        CMD_STICK: begin
          if (!cmd_i.en) begin
            pin_miso_d = 1'b0;
          end else if (cmd_i.sclk != phase_q) begin
            phase_d = cmd_i.sclk;
            if (!cmd_i.sclk && ((rx_pos_q != POS_BIT0) || cmd_i.sync)) begin
              armed_d  = 1'b1;
              do_take  = 1'b1;
              take_lvl = cmd_i.mosi;
            end else if (armed_q || (tx_pos_q != POS_BIT0)) begin
              if (tx_pos_q == POS_LAST) begin
                pop        = 1'b1;
                tx_pos_d   = POS_BIT0;
                armed_d    = 1'b0;
                pin_miso_d = (count_q > CNT_ONE) ? next_byte_q[0] : 1'b0;
              end else begin
                tx_pos_d   = tx_pos_inc;
                pin_miso_d = hb[tx_pos_inc];
              end
            end else begin
              pin_miso_d = hb[tx_pos_q];
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (do_take) begin
      rx_next[rx_pos_q] = take_lvl;
      rx_pos_d          = rx_pos_q + POS_W'(1);
      if (rx_pos_q == POS_LAST) begin
        rsp.rx_valid = 1'b1;
        rsp.rx_byte  = rx_next;
        rx_shift_d   = '0;
      end else begin
        rx_shift_d   = rx_next;
      end
    end

    if (pop && (count_q != '0)) begin
      head_d      = ptr_inc(head_q);
      count_d     = count_q - CW'(1);
      head_byte_d = next_byte_q;
      nb_ok_d     = 1'b0;
      rf1_d       = 1'b1;
    end

    rsp.sclk = pin_clk_d;
    rsp.mosi = pin_mosi_d;
    rsp.sync = pin_sync_d;
    rsp.miso = pin_miso_d;

    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
      out_d       = rsp;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      nb_ok_q     <= 1'b0;
      rf1_q       <= 1'b0;
      rf2_q       <= 1'b0;
      tx_pos_q    <= '0;
      rx_pos_q    <= '0;
      rx_shift_q  <= '0;
      phase_q     <= 1'b0;
      armed_q     <= 1'b0;
      pin_clk_q   <= 1'b0;
      pin_mosi_q  <= 1'b0;
      pin_sync_q  <= 1'b0;
      pin_miso_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      nb_ok_q     <= nb_ok_d;
      rf1_q       <= rf1_d;
      rf2_q       <= rf2_d;
      tx_pos_q    <= tx_pos_d;
      rx_pos_q    <= rx_pos_d;
      rx_shift_q  <= rx_shift_d;
      phase_q     <= phase_d;
      armed_q     <= armed_d;
      pin_clk_q   <= pin_clk_d;
      pin_mosi_q  <= pin_mosi_d;
      pin_sync_q  <= pin_sync_d;
      pin_miso_q  <= pin_miso_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_byte_q <= head_byte_d;
    next_byte_q <= next_byte_d;
    out_q       <= out_d;
  end

  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = out_q;

endmodule

// ----- rtl/core/bitbang_spi_master_slave.sv -----
// Top level of the tick-driven LSB-first SPI master/slave engine.
// The result of an item is on m_axis once it has passed the queue slot and the result register.
// Throughput: one item per cycle unless m_axis stalls, set by engine step and result register.
// The transmit FIFO head and next entry sit in flops; the RAM refills the next entry
// after a pop, well before the next pop, which comes at least eight items later.
// Reset (rst_ni, async low): empty FIFO, bit counters, pins and role (slave) cleared; no sweep.
`timescale 1ns / 1ps

module bitbang_spi_master_slave #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // role register: 1 = master, 0 = slave
  input  logic                            cfg_we_i,
  input  logic                            cfg_wdata_i,
  // input item stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // put_byte[7:0], enable_level[8], miso_in[9], mosi_in[10], clk_in[11],
  // sync_in[12], zero[15:13]
  input  logic [bbspi_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // kind[0]: 0 tick, 1 put
  input  logic                            s_axis_tuser,
  // result item stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // clk_out[0], mosi_out[1], sync_out[2], miso_out[3], rx_valid[4],
  // rx_byte[12:5], put_dropped[13], zero[15:14]
  output logic [bbspi_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  import bbspi_pkg::*;

  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;
  rsp_t rsp;

  // Front: owns the role bit, turns each item into put / master tick /
  // slave tick.
  bbspi_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .cmd_o         (push_cmd)
  );

  // Two-deep queue so the input side keeps flowing while a result waits.
  bbspi_cmdq u_cmdq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  // Engine: FIFO, shift registers, pin state; registers one result per item.
  bbspi_engine #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (pop_valid),
    .cmd_ready_o (pop_ready),
    .cmd_i       (pop_cmd),
    .rsp_valid_o (m_axis_tvalid),
    .rsp_ready_i (m_axis_tready),
    .rsp_o       (rsp)
  );

  assign m_axis_tdata = {2'b00, rsp.dropped, rsp.rx_byte, rsp.rx_valid,
                         rsp.miso, rsp.sync, rsp.mosi, rsp.sclk};

endmodule

// ----- sim/tb_bitbang_spi_master_slave.sv -----
// Self-checking testbench for the bit-banged SPI master/slave engine.
`timescale 1ns / 1ps

module tb_bitbang_spi_master_slave;
  import bbspi_pkg::*;

  localparam int unsigned FIFO_DEPTH  = 16;
  localparam int unsigned STALL_LIMIT = 2000;  // cycles with no handshake on either side
  localparam int unsigned HOLD_CYCLES = 80;    // long receiver hold-off, fills the pipe
  localparam int unsigned N_PHASES    = 6;
  localparam int unsigned PHASE_ITEMS = 75;
  localparam int unsigned MAX_REPORTS = 10;

  // role of each random phase, bit p for phase p (master, master back to back included)
  localparam logic [N_PHASES-1:0] PHASE_ROLE = 6'b011010;

  // Field order matches {tuser, tdata[12:0]}: the struct is the bus image of an item.
  typedef struct packed {
    logic       kind;
    logic       sync;
    logic       sclk;
    logic       mosi;
    logic       miso;
    logic       en;
    logic [7:0] pbyte;
  } spi_item_t;

  // One row of the directed table. A config row writes 'role'; an item row sends
  // 'item' 'reps' times and, where 'typed' is set, expects 'typed_rsp' verbatim.
  typedef struct packed {
    logic        is_cfg;
    logic        role;
    spi_item_t   item;
    logic [5:0]  reps;
    logic        typed;
    logic [15:0] typed_rsp;
  } dir_row_t;

  localparam int unsigned N_ROWS = 13;
  localparam dir_row_t DIR_TAB [N_ROWS] = '{
    // role: slave
    '{1'b1, 1'b0, '{KIND_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00}, 6'd0, 1'b0, 16'h0000},
    // slave held right after reset: every pin low
    '{1'b0, 1'b0, '{KIND_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00}, 6'd1, 1'b1, 16'h0000},
    // fill the FIFO: all-ones byte at the head, then zeros
    '{1'b0, 1'b0, '{KIND_PUT,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'hFF}, 6'd1, 1'b1, 16'h0000},
    '{1'b0, 1'b0, '{KIND_PUT,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00}, 6'd15, 1'b1, 16'h0000},
    // FIFO full: put dropped, flag raised
    '{1'b0, 1'b0, '{KIND_PUT,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h5A}, 6'd1, 1'b1, 16'h2000},
    // rising sclk before any sync: not armed, MISO shows bit 0
    '{1'b0, 1'b0, '{KIND_TICK, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 8'h00}, 6'd1, 1'b0, 16'h0000},
    // falling sclk with sync: arms and samples MOSI
    '{1'b0, 1'b0, '{KIND_TICK, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 8'h00}, 6'd1, 1'b0, 16'h0000},
    // no clock change: nothing moves
    '{1'b0, 1'b0, '{KIND_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'h00}, 6'd1, 1'b0, 16'h0000},
    // slave held: MISO forced low, sclk level ignored
    '{1'b0, 1'b0, '{KIND_TICK, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00}, 6'd1, 1'b1, 16'h0000},
    // rising sclk once armed: next transmit bit
    '{1'b0, 1'b0, '{KIND_TICK, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 8'h00}, 6'd1, 1'b0, 16'h0000},
    // role: master, slave state kept
    '{1'b1, 1'b1, '{KIND_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00}, 6'd0, 1'b0, 16'h0000},
    // master ticks; slave-side pins and byte field are don't-care
    '{1'b0, 1'b0, '{KIND_TICK, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 8'hFF}, 6'd4, 1'b0, 16'h0000},
    // master held: clock forced low
    '{1'b0, 1'b0, '{KIND_TICK, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00}, 6'd1, 1'b0, 16'h0000}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;

  bitbang_spi_master_slave #(
    .QUEUE_DEPTH(FIFO_DEPTH)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // ---------------------------------------------------------------------------
  // Engine predictor state (reset values)
  // ---------------------------------------------------------------------------
  logic             role_master = 1'b0;
  logic [7:0]       fifo_mem [FIFO_DEPTH] = '{default: '0};
  logic [3:0]       fifo_head = '0;
  logic [4:0]       fifo_cnt  = '0;   // includes the byte being shifted out
  logic [POS_W-1:0] tx_pos    = POS_BIT0;
  logic [POS_W-1:0] rx_pos    = POS_BIT0;
  logic [7:0]       rx_acc    = '0;
  logic             phase     = 1'b0; // master: clock phase, slave: last seen sclk
  logic             armed     = 1'b0;
  logic             pin_clk   = 1'b0;
  logic             pin_mosi  = 1'b0;
  logic             pin_sync  = 1'b0;
  logic             pin_miso  = 1'b0;

  logic [15:0] rsp_due_q [$];   // expected result words, oldest first
  int unsigned n_mismatch = 0;
  int unsigned n_results  = 0;
  int unsigned stall_cnt  = 0;

  // stimulus controls shared by the two drivers
  logic        calm     = 1'b0;   // no idling on either side
  logic        hold_req = 1'b0;   // ask the receiver for one long hold-off
  logic        cur_typed;
  logic [15:0] cur_typed_rsp;

  // current transmit bit; an empty FIFO sends zeros
  function automatic logic head_bit();
    return (fifo_cnt != 0) ? fifo_mem[fifo_head][tx_pos] : 1'b0;
  endfunction

  function automatic void fifo_pop();
    if (fifo_cnt != 0) begin
      fifo_head = fifo_head + 4'd1;
      fifo_cnt  = fifo_cnt - 5'd1;
    end
  endfunction

  // Advances the predictor by one item and returns the result it should produce.
  function automatic rsp_t spi_engine_step(spi_item_t it);
    rsp_t       r;
    logic [3:0] slot;
    logic       take;
    logic       lvl;
    r    = '0;
    take = 1'b0;
    lvl  = 1'b0;
    if (it.kind == KIND_PUT) begin
      if (fifo_cnt == 5'(FIFO_DEPTH)) begin
        r.dropped = 1'b1;
      end else begin
        slot           = fifo_head + fifo_cnt[3:0];
        fifo_mem[slot] = it.pbyte;
        fifo_cnt       = fifo_cnt + 5'd1;
      end
    end else if (role_master) begin
      if (!it.en) begin
        pin_clk = 1'b0;
        phase   = 1'b0;
      end else begin
        phase   = ~phase;
        pin_clk = ~pin_clk;
        if (!phase) begin
          // falling edge: sample MISO
          take = 1'b1;
          lvl  = it.miso;
        end else begin
          // rising edge: drive the next bit, sync marks bit 0
          pin_sync = (tx_pos == POS_BIT0);
          pin_mosi = head_bit();
          if (tx_pos == POS_LAST) begin
            fifo_pop();
            tx_pos = POS_BIT0;
          end else begin
            tx_pos = tx_pos + 1'b1;
          end
        end
      end
    end else begin
      if (!it.en) begin
        pin_miso = 1'b0;
      end else if (it.sclk != phase) begin
        phase = it.sclk;
        if (!it.sclk && (rx_pos != POS_BIT0 || it.sync)) begin
          armed = 1'b1;
          take  = 1'b1;
          lvl   = it.mosi;
        end else begin
          if (armed || tx_pos != POS_BIT0) begin
            if (tx_pos == POS_LAST) begin
              fifo_pop();
              tx_pos = POS_BIT0;
              armed  = 1'b0;
            end else begin
              tx_pos = tx_pos + 1'b1;
            end
          end
          pin_miso = head_bit();
        end
      end
    end
    if (take) begin
      rx_acc[rx_pos] = lvl;
      if (rx_pos == POS_LAST) begin
        r.rx_valid = 1'b1;
        r.rx_byte  = rx_acc;
        rx_acc     = '0;
        rx_pos     = POS_BIT0;
      end else begin
        rx_pos = rx_pos + 1'b1;
      end
    end
    r.sclk = pin_clk;
    r.mosi = pin_mosi;
    r.sync = pin_sync;
    r.miso = pin_miso;
    return r;
  endfunction

  // Field-by-field compare of one result word, padding included.
  function automatic void check_result(logic [15:0] want, logic [15:0] got);
    rsp_t w;
    rsp_t g;
    logic bad;
    w   = want[13:0];
    g   = got[13:0];
    bad = (got[15:14] != want[15:14]);
    if (g.sclk     != w.sclk)     bad = 1'b1;
    if (g.mosi     != w.mosi)     bad = 1'b1;
    if (g.sync     != w.sync)     bad = 1'b1;
    if (g.miso     != w.miso)     bad = 1'b1;
    if (g.rx_valid != w.rx_valid) bad = 1'b1;
    if (g.rx_byte  != w.rx_byte)  bad = 1'b1;
    if (g.dropped  != w.dropped)  bad = 1'b1;
    if (bad) begin
      n_mismatch++;
      if (n_mismatch <= MAX_REPORTS) begin
        $display("result %0d: exp clk=%b mosi=%b sync=%b miso=%b rxv=%b rx=%02h drop=%b pad=%b",
                 n_results, w.sclk, w.mosi, w.sync, w.miso, w.rx_valid, w.rx_byte,
                 w.dropped, want[15:14]);
        $display("           got clk=%b mosi=%b sync=%b miso=%b rxv=%b rx=%02h drop=%b pad=%b",
                 g.sclk, g.mosi, g.sync, g.miso, g.rx_valid, g.rx_byte, g.dropped,
                 got[15:14]);
      end
    end
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Monitor: results are retired before the item of the same edge is predicted,
  // and the registered path through the DUT never lets an item meet its own result.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    rsp_t pred;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (rsp_due_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= MAX_REPORTS)
            $display("result %0d: none expected, got %04h", n_results, m_axis_tdata);
        end else begin
          check_result(rsp_due_q.pop_front(), m_axis_tdata);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pred = spi_engine_step(spi_item_t'({s_axis_tuser, s_axis_tdata[12:0]}));
        rsp_due_q.push_back(cur_typed ? cur_typed_rsp : {2'b00, pred});
      end
      // watchdog on handshake progress
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cnt = 0;
      end else begin
        stall_cnt++;
        if (stall_cnt >= STALL_LIMIT) begin
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result sink: random back-pressure, one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : sink
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 25);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Item source
  // ---------------------------------------------------------------------------
  // Offers one item after random gaps; returns at the edge it is taken.
  task automatic send_item(spi_item_t it, logic typed, logic [15:0] typed_rsp);
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < 25) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.kind;
    s_axis_tdata  <= {3'b000, it[12:0]};
    cur_typed     <= typed;
    cur_typed_rsp <= typed_rsp;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stops offering and waits until every result is back, plus the block latency.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (rsp_due_q.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // Role writes only with the engine idle.
  task automatic write_role(logic m);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    role_master = m;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin : stim
    spi_item_t   it;
    int unsigned roll;
    int unsigned burst_left;
    logic        ext_clk;
    burst_left    = 0;
    ext_clk       = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = KIND_TICK;
    cur_typed     = 1'b0;
    cur_typed_rsp = '0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    for (int r = 0; r < N_ROWS; r++) begin
      if (DIR_TAB[r].is_cfg) begin
        write_role(DIR_TAB[r].role);
      end else begin
        repeat (DIR_TAB[r].reps)
          send_item(DIR_TAB[r].item, DIR_TAB[r].typed, DIR_TAB[r].typed_rsp);
      end
    end

    // random phases: mostly enabled ticks with a toggling external clock in slave
    // role, a steady trickle of puts with occasional bursts that overrun the FIFO,
    // and some items with every field random
    for (int p = 0; p < N_PHASES; p++) begin
      write_role(PHASE_ROLE[p]);
      calm = (p == 3);
      if (p == 1) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        it   = spi_item_t'(14'($urandom));
        roll = $urandom_range(0, 99);
        if (burst_left != 0) begin
          it.kind = KIND_PUT;
          burst_left--;
        end else if (roll < 14) begin
          it.kind = KIND_PUT;
          if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(4, 14);
        end else if (roll >= 22) begin
          it.kind = KIND_TICK;
          it.en   = ($urandom_range(0, 15) != 0);
          if ($urandom_range(0, 99) < 85) ext_clk = ~ext_clk;
          it.sclk = ext_clk;
          it.sync = ($urandom_range(0, 3) == 0);
        end
        send_item(it, 1'b0, 16'h0000);
      end
    end

    drain();
    repeat (4) @(negedge clk_i);
    if (n_mismatch == 0 && rsp_due_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
